FILE: rtl/string_intern_table_assert.svh
// Assertion macros for the string interning table.
// Used by the top level only; relies on clk and rst_n being in scope.
`ifndef STRING_INTERN_TABLE_ASSERT_SVH
`define STRING_INTERN_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SIT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("string_intern_table: check failed");

// Next-cycle implication, disabled during reset.
`define SIT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("string_intern_table: check failed");

`endif

FILE: rtl/sit_pkg.sv
// Shared types and constants for the string interning table.
// No dependencies; used by sit_entry_store and string_intern_table.
package sit_pkg;

  localparam int ENTRIES_DEF = 256;
  localparam int BUCKETS     = 32;
  localparam int BUCKET_BITS = 5;
  localparam int MAX_LEN_DEF = 32;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_TOO_LONG = 2'd2
  } status_t;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_HEAD   = 9'b000000010,
    ST_FETCH  = 9'b000000100,
    ST_NODE   = 9'b000001000,
    ST_LEN    = 9'b000010000,
    ST_CMP    = 9'b000100000,
    ST_COMMIT = 9'b001000000,
    ST_LINK   = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_t;

  typedef struct packed {
    logic byte_we;
    logic pend_we;
    logic len_we;
    logic next_we;
  } store_ctl_t;

endpackage

FILE: rtl/sit_entry_store.sv
// Entry storage: lexeme bytes, lengths, chain links and the pending lexeme.
// Synchronous memories with registered reads; depends on sit_pkg.
module sit_entry_store #(
  parameter int ENTRIES = sit_pkg::ENTRIES_DEF,
  parameter int MAX_LEN = sit_pkg::MAX_LEN_DEF,
  localparam int IW = $clog2(ENTRIES),
  localparam int AW = $clog2(MAX_LEN),
  localparam int LW = $clog2(MAX_LEN + 1)
) (
  input  logic                clk,
  input  sit_pkg::store_ctl_t ctl,
  input  logic [IW-1:0]       wr_entry,
  input  logic [AW-1:0]       wr_pos,
  input  logic [7:0]          wr_byte,
  input  logic [LW-1:0]       wr_len,
  input  logic [IW-1:0]       next_addr,
  input  logic [IW:0]         next_data,
  input  logic [IW-1:0]       rd_entry,
  input  logic [AW-1:0]       rd_pos,
  output logic [7:0]          rd_byte,
  output logic [7:0]          rd_pend,
  output logic [LW-1:0]       rd_len,
  output logic [IW:0]         rd_next
);

  localparam int BYTE_DEPTH = ENTRIES * (2 ** AW);

  logic [7:0]    byte_mem [BYTE_DEPTH];
  logic [7:0]    pend_mem [2 ** AW];
  logic [LW-1:0] len_mem  [ENTRIES];
  logic [IW:0]   next_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (ctl.byte_we) begin
      byte_mem[{wr_entry, wr_pos}] <= wr_byte;
    end
    rd_byte <= byte_mem[{rd_entry, rd_pos}];
  end

  always_ff @(posedge clk) begin
    if (ctl.pend_we) begin
      pend_mem[wr_pos] <= wr_byte;
    end
    rd_pend <= pend_mem[rd_pos];
  end

  always_ff @(posedge clk) begin
    if (ctl.len_we) begin
      len_mem[wr_entry] <= wr_len;
    end
    rd_len <= len_mem[rd_entry];
  end

  always_ff @(posedge clk) begin
    if (ctl.next_we) begin
      next_mem[next_addr] <= next_data;
    end
    rd_next <= next_mem[rd_entry];
  end

endmodule

FILE: rtl/string_intern_table.sv
// String interning table top level: byte stream intake, chain walk and insert.
// Depends on sit_pkg, sit_entry_store and string_intern_table_assert.svh.
//
// Lexemes arrive one byte per transaction (in_tdata), op in in_tuser and the
// final byte marked by in_tlast. Unless the lexeme is too long, the final
// byte starts a search of its bucket chain: HEAD and FETCH read the bucket
// head; each entry then visits NODE and LEN (length, first byte) and, on a
// match, CMP (further bytes). A hit ends the walk; an insert miss writes the
// new entry in COMMIT and, if the chain is not empty, links it in LINK. The
// walk is paced by the single read port of the entry byte memory. One result
// transaction follows each final byte, with entry_index in out_tdata and
// found and status in out_tuser. Bytes are accepted while a result waits.
`include "string_intern_table_assert.svh"

module string_intern_table #(
  parameter int ENTRIES = sit_pkg::ENTRIES_DEF,
  parameter int MAX_LEN = sit_pkg::MAX_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // char_code[7:0]
  input  logic [0:0] in_tuser,   // op[0]
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // entry_index[7:0]
  output logic [2:0] out_tuser   // found[0], status[2:1]
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = IW + 1;
  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int BB = sit_pkg::BUCKET_BITS;

  sit_pkg::state_t state_r, state_nxt;

  logic [LW-1:0] plen_r, plen_nxt;
  logic          too_long_r, too_long_nxt;
  logic          pop_r, pop_nxt;
  logic [BB-1:0] sum_r, sum_nxt;
  logic [BB-1:0] bucket_r, bucket_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic          cur_vld_r, cur_vld_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic          tail_vld_r, tail_vld_nxt;
  logic [IW:0]   next_r, next_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] res_idx_r, res_idx_nxt;
  logic          res_fnd_r, res_fnd_nxt;
  sit_pkg::status_t res_st_r, res_st_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_idx_r, out_idx_nxt;
  logic          out_fnd_r, out_fnd_nxt;
  logic [1:0]    out_st_r, out_st_nxt;

  logic [IW-1:0]      head_mem [sit_pkg::BUCKETS];
  logic [IW-1:0]      head_q;
  logic [sit_pkg::BUCKETS-1:0] head_vld_r, head_vld_nxt;
  logic               head_we;

  sit_pkg::store_ctl_t ctl;
  logic [IW-1:0] wr_entry;
  logic [IW-1:0] next_addr;
  logic [IW:0]   next_data;
  logic [7:0]    rd_byte, rd_pend;
  logic [LW-1:0] rd_len;
  logic [IW:0]   rd_next;

  logic          in_acc;
  logic          tl;
  logic          room;
  logic          byte_eq;
  logic [IW+7:0] idx_ext;

  assign in_tready = (state_r == sit_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign tl        = too_long_r || (plen_r == LW'(MAX_LEN));
  assign room      = (count_r < CW'(ENTRIES));
  assign byte_eq   = (rd_byte == rd_pend);
  assign idx_ext   = {8'b0, res_idx_r};

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[bucket_r] <= count_r[IW-1:0];
    end
    head_q <= head_mem[bucket_r];
  end

  sit_entry_store #(
    .ENTRIES (ENTRIES),
    .MAX_LEN (MAX_LEN)
  ) u_store (
    .clk       (clk),
    .ctl       (ctl),
    .wr_entry  (wr_entry),
    .wr_pos    (plen_r[AW-1:0]),
    .wr_byte   (in_tdata),
    .wr_len    (plen_r),
    .next_addr (next_addr),
    .next_data (next_data),
    .rd_entry  (cur_r),
    .rd_pos    (idx_r[AW-1:0]),
    .rd_byte   (rd_byte),
    .rd_pend   (rd_pend),
    .rd_len    (rd_len),
    .rd_next   (rd_next)
  );

  assign wr_entry = count_r[IW-1:0];

  always_comb begin
    state_nxt     = state_r;
    plen_nxt      = plen_r;
    too_long_nxt  = too_long_r;
    pop_nxt       = pop_r;
    sum_nxt       = sum_r;
    bucket_nxt    = bucket_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    cur_vld_nxt   = cur_vld_r;
    tail_nxt      = tail_r;
    tail_vld_nxt  = tail_vld_r;
    next_nxt      = next_r;
    idx_nxt       = idx_r;
    res_idx_nxt   = res_idx_r;
    res_fnd_nxt   = res_fnd_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_idx_nxt   = out_idx_r;
    out_fnd_nxt   = out_fnd_r;
    out_st_nxt    = out_st_r;
    head_vld_nxt  = head_vld_r;
    head_we       = 1'b0;
    ctl           = '0;
    next_addr     = count_r[IW-1:0];
    next_data     = '0;

    case (state_r)
      sit_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (plen_r == '0 && !too_long_r) begin
            pop_nxt = in_tuser[0];
          end
          if (!tl) begin
            ctl.pend_we = 1'b1;
            ctl.byte_we = room;
            plen_nxt    = plen_r + LW'(1);
          end else begin
            too_long_nxt = 1'b1;
          end
          sum_nxt = sum_r + in_tdata[BB-1:0];
          if (in_tlast) begin
            bucket_nxt  = sum_nxt;
            idx_nxt     = '0;
            res_idx_nxt = '0;
            res_fnd_nxt = 1'b0;
            res_st_nxt  = sit_pkg::STATUS_OK;
            if (tl) begin
              res_st_nxt = sit_pkg::STATUS_TOO_LONG;
              state_nxt  = sit_pkg::ST_DONE;
            end else begin
              state_nxt = sit_pkg::ST_HEAD;
            end
          end
        end
      end
      sit_pkg::ST_HEAD: begin
        state_nxt = sit_pkg::ST_FETCH;
      end
      sit_pkg::ST_FETCH: begin
        cur_nxt      = head_q;
        cur_vld_nxt  = head_vld_r[bucket_r];
        tail_vld_nxt = 1'b0;
        state_nxt    = sit_pkg::ST_NODE;
      end
      sit_pkg::ST_NODE: begin
        if (cur_vld_r) begin
          idx_nxt   = LW'(1);
          state_nxt = sit_pkg::ST_LEN;
        end else if (pop_r == sit_pkg::OP_LOOKUP) begin
          state_nxt = sit_pkg::ST_DONE;
        end else if (!room) begin
          res_st_nxt = sit_pkg::STATUS_FULL;
          state_nxt  = sit_pkg::ST_DONE;
        end else begin
          state_nxt = sit_pkg::ST_COMMIT;
        end
      end
      sit_pkg::ST_LEN: begin
        next_nxt = rd_next;
        if (rd_len != plen_r || !byte_eq) begin
          cur_nxt      = rd_next[IW-1:0];
          cur_vld_nxt  = rd_next[IW];
          tail_nxt     = cur_r;
          tail_vld_nxt = 1'b1;
          idx_nxt      = '0;
          state_nxt    = sit_pkg::ST_NODE;
        end else if (plen_r == LW'(1)) begin
          res_idx_nxt = cur_r;
          res_fnd_nxt = 1'b1;
          state_nxt   = sit_pkg::ST_DONE;
        end else begin
          idx_nxt   = idx_r + LW'(1);
          state_nxt = sit_pkg::ST_CMP;
        end
      end
      sit_pkg::ST_CMP: begin
        if (!byte_eq) begin
          cur_nxt      = next_r[IW-1:0];
          cur_vld_nxt  = next_r[IW];
          tail_nxt     = cur_r;
          tail_vld_nxt = 1'b1;
          idx_nxt      = '0;
          state_nxt    = sit_pkg::ST_NODE;
        end else if (idx_r == plen_r) begin
          res_idx_nxt = cur_r;
          res_fnd_nxt = 1'b1;
          state_nxt   = sit_pkg::ST_DONE;
        end else begin
          idx_nxt = idx_r + LW'(1);
        end
      end
      sit_pkg::ST_COMMIT: begin
        ctl.len_we  = 1'b1;
        ctl.next_we = 1'b1;
        next_addr   = count_r[IW-1:0];
        next_data   = '0;
        res_idx_nxt = count_r[IW-1:0];
        if (tail_vld_r) begin
          state_nxt = sit_pkg::ST_LINK;
        end else begin
          head_we                = 1'b1;
          head_vld_nxt[bucket_r] = 1'b1;
          count_nxt              = count_r + CW'(1);
          state_nxt              = sit_pkg::ST_DONE;
        end
      end
      sit_pkg::ST_LINK: begin
        ctl.next_we = 1'b1;
        next_addr   = tail_r;
        next_data   = {1'b1, count_r[IW-1:0]};
        count_nxt   = count_r + CW'(1);
        state_nxt   = sit_pkg::ST_DONE;
      end
      sit_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = idx_ext[7:0];
          out_fnd_nxt   = res_fnd_r;
          out_st_nxt    = res_st_r;
          plen_nxt      = '0;
          too_long_nxt  = 1'b0;
          pop_nxt       = sit_pkg::OP_INSERT;
          sum_nxt       = '0;
          state_nxt     = sit_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sit_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sit_pkg::ST_IDLE;
      plen_r      <= '0;
      too_long_r  <= 1'b0;
      pop_r       <= sit_pkg::OP_INSERT;
      sum_r       <= '0;
      count_r     <= '0;
      head_vld_r  <= '0;
      out_valid_r <= 1'b0;
      cur_vld_r   <= 1'b0;
      tail_vld_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      plen_r      <= plen_nxt;
      too_long_r  <= too_long_nxt;
      pop_r       <= pop_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      head_vld_r  <= head_vld_nxt;
      out_valid_r <= out_valid_nxt;
      cur_vld_r   <= cur_vld_nxt;
      tail_vld_r  <= tail_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bucket_r  <= bucket_nxt;
    cur_r     <= cur_nxt;
    tail_r    <= tail_nxt;
    next_r    <= next_nxt;
    idx_r     <= idx_nxt;
    res_idx_r <= res_idx_nxt;
    res_fnd_r <= res_fnd_nxt;
    res_st_r  <= res_st_nxt;
    out_idx_r <= out_idx_nxt;
    out_fnd_r <= out_fnd_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_idx_r;
  assign out_tuser  = {out_st_r, out_fnd_r};

  `SIT_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(ENTRIES))
  `SIT_ASSERT_IMP(a_link_has_tail, state_r == sit_pkg::ST_LINK, tail_vld_r)
  `SIT_ASSERT_IMP(a_too_long_no_hit, out_valid_r && out_st_r == sit_pkg::STATUS_TOO_LONG,
                  !out_fnd_r && out_idx_r == 8'd0)
  `SIT_ASSERT_NXT(a_insert_counts, state_r == sit_pkg::ST_LINK,
                  count_r == $past(count_r) + CW'(1))

endmodule
